FILE: rtl/ordered_byte_list_store_defines.svh
// Assertion macros shared by the ordered byte list store RTL.
`ifndef ORDERED_BYTE_LIST_STORE_DEFINES_SVH
`define ORDERED_BYTE_LIST_STORE_DEFINES_SVH

// Check a property at every clock edge outside reset.
`define OBLST_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Check a property at every clock edge, reset included.
`define OBLST_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

FILE: rtl/oblst_pkg.sv
// Types and codes shared by the ordered byte list store.
`timescale 1ns / 1ps
`default_nettype none

package oblst_pkg;

    localparam logic [1:0] KIND_APPEND = 2'd0;
    localparam logic [1:0] KIND_READ   = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [5:0] slot_index;
        logic [7:0] new_value;
    } t_in_word;

    typedef struct packed {
        logic [7:0] found_value;
        logic [1:0] status;
        logic [6:0] item_count;
    } t_out_word;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_SHIFT,
        S_RESP
    } t_state;

endpackage

`default_nettype wire

FILE: rtl/ordered_byte_list_store.sv
// Append and invalid requests go from accept straight to S_RESP; read and remove pass S_FETCH first.
// Remove then shifts every later entry down in S_SHIFT, one entry moved per
// cycle through the single-port-write, single-port-read entry memory.
// A new word is taken once the previous result has moved to the output register.
// Reset clears the element count, the FSM and the output valid; the entry memory
// keeps its contents and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

`include "ordered_byte_list_store_defines.svh"

module ordered_byte_list_store
    import oblst_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_word  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_word      o_out_data
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > 6) ? CW : 6;
    localparam int XW = (CW > 7) ? CW : 7;

    // entry memory
    logic [7:0]    mem [CAPACITY];
    logic [7:0]    r_rd_data;
    logic          mem_re;
    logic [IW-1:0] rd_addr;
    logic          mem_we;
    logic [IW-1:0] wr_addr;
    logic [7:0]    wr_data;

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_ptr, n_ptr;
    logic [IW-1:0] r_wptr, n_wptr;
    logic          r_remove, n_remove;
    logic [7:0]    r_res_value, n_res_value;
    logic [1:0]    r_res_status, n_res_status;
    logic          r_out_valid;
    t_out_word     r_out;

    logic          in_fire;
    logic          out_free;
    logic [PW-1:0] pos_x;
    logic [PW-1:0] count_p;
    logic [XW-1:0] count_x;
    logic          store_full;
    logic          pos_bad;
    logic          req_fetch;
    logic          more_shift;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign pos_x      = PW'(i_in_data.slot_index);
    assign count_p    = PW'(r_count);
    assign count_x    = XW'(r_count);
    assign store_full = (r_count == CW'(CAPACITY));
    assign pos_bad    = (pos_x >= count_p);
    assign req_fetch  = ((i_in_data.kind == KIND_READ) || (i_in_data.kind == KIND_REMOVE))
                        && !pos_bad;
    assign more_shift = (r_ptr < r_count);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = req_fetch ? S_FETCH : S_RESP;
                end
            end
            S_FETCH: begin
                n_state = (r_remove && more_shift) ? S_SHIFT : S_RESP;
            end
            S_SHIFT: begin
                if (!more_shift) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath control
    always_comb begin
        mem_re       = 1'b0;
        rd_addr      = '0;
        mem_we       = 1'b0;
        wr_addr      = '0;
        wr_data      = '0;
        n_count      = r_count;
        n_ptr        = r_ptr;
        n_wptr       = r_wptr;
        n_remove     = r_remove;
        n_res_value  = r_res_value;
        n_res_status = r_res_status;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_res_value  = '0;
                    n_res_status = ST_INVALID;
                    n_remove     = (i_in_data.kind == KIND_REMOVE);
                    unique case (i_in_data.kind)
                        KIND_APPEND: begin
                            if (store_full) begin
                                n_res_status = ST_FULL;
                            end else begin
                                mem_we       = 1'b1;
                                wr_addr      = r_count[IW-1:0];
                                wr_data      = i_in_data.new_value;
                                n_count      = r_count + CW'(1);
                                n_res_status = ST_OK;
                            end
                        end
                        KIND_READ, KIND_REMOVE: begin
                            if (!pos_bad) begin
                                mem_re  = 1'b1;
                                rd_addr = pos_x[IW-1:0];
                                n_ptr   = pos_x[CW-1:0] + CW'(1);
                                n_wptr  = pos_x[IW-1:0];
                            end
                        end
                        default: n_res_status = ST_INVALID;
                    endcase
                end
            end
            S_FETCH: begin
                n_res_value  = r_rd_data;
                n_res_status = ST_OK;
                if (r_remove) begin
                    if (more_shift) begin
                        // prefetch the entry after the hole
                        mem_re  = 1'b1;
                        rd_addr = r_ptr[IW-1:0];
                        n_ptr   = r_ptr + CW'(1);
                    end else begin
                        n_count = r_count - CW'(1);
                    end
                end
            end
            S_SHIFT: begin
                // move one entry down, fetch the next one
                mem_we  = 1'b1;
                wr_addr = r_wptr;
                wr_data = r_rd_data;
                n_wptr  = r_wptr + IW'(1);
                if (more_shift) begin
                    mem_re  = 1'b1;
                    rd_addr = r_ptr[IW-1:0];
                    n_ptr   = r_ptr + CW'(1);
                end else begin
                    n_count = r_count - CW'(1);
                end
            end
            S_RESP: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        if (mem_re) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (r_state == S_RESP && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr        <= n_ptr;
        r_wptr       <= n_wptr;
        r_remove     <= n_remove;
        r_res_value  <= n_res_value;
        r_res_status <= n_res_status;
        if (r_state == S_RESP && out_free) begin
            r_out.found_value <= r_res_value;
            r_out.status      <= r_res_status;
            r_out.item_count  <= count_x[6:0];
        end
    end

    `OBLST_ASSERT_ALWAYS(a_reset_clear, !i_rst_n |=> (r_count == '0) && !r_out_valid, "not cleared")
    `OBLST_ASSERT(a_count_bound, r_count <= CW'(CAPACITY), "count beyond capacity")
    `OBLST_ASSERT(a_no_port_clash, (mem_we && mem_re) |-> (wr_addr != rd_addr), "read and write hit the same entry")
    `OBLST_ASSERT(a_fail_zero, (r_out_valid && r_out.status != ST_OK) |-> (r_out.found_value == 8'd0), "failed request carries a value")
    `OBLST_ASSERT(a_count_step, (r_count == $past(r_count)) || (r_count == $past(r_count) + CW'(1)) || (r_count == $past(r_count) - CW'(1)), "count moved by more than one")
    `OBLST_ASSERT(a_shift_order, (r_state == S_SHIFT) |-> (r_ptr <= r_count), "shift pointer ran past the count")

endmodule

`default_nettype wire
